@@ rtl/core/pprt_pkg.sv @@
// Shared types and codes for the PID packet-rate table.
package pprt_pkg;

  localparam int PID_W   = 13;
  localparam int CNT_W   = 16;
  localparam int IDX_W   = 6;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int USED_W  = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [FUNC_W-1:0] FN_PACKET = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TICK   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DISABLED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

  typedef struct packed {
    logic [PID_W-1:0] key;
    logic [CNT_W-1:0] prev;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_P_RD   = 10'b00_0000_0010,
    ST_P_CMP  = 10'b00_0000_0100,
    ST_M_RD   = 10'b00_0000_1000,
    ST_M_WR   = 10'b00_0001_0000,
    ST_T_RD   = 10'b00_0010_0000,
    ST_T_CMP  = 10'b00_0100_0000,
    ST_R_RD   = 10'b00_1000_0000,
    ST_R_WAIT = 10'b01_0000_0000,
    ST_FIN    = 10'b10_0000_0000
  } state_t;

endpackage

@@ rtl/core/pid_packet_rate_table_core.sv @@
// Top level of the PID packet-rate table: sequencer, entry memory and result register.
//
// Items arrive on the in_ stream: tuser carries the function (packet, window tick,
// read, clear), tdata the PID and the table index. Each item gives exactly one
// result on the out_ stream: tuser carries the status, tdata the entry read and
// the number of entries in use. The cfg_ channel writes the collecting-enabled bit.
// The table lives in one memory with one write and one registered read port, and
// a single key comparator is stepped over it. A packet item walks the sorted entries
// from the start; if its PID is present its count is bumped, else the entries from its
// sorted position upward are shifted up one place and the PID is inserted there. A
// window tick walks every entry in use once. in_tready is high only while no item
// is in work. A finished result sits in the output register; if the receiver
// stalls, the next item is still accepted and processed, and its result waits
// until the register is taken. Reset empties the table and disables collecting;
// no memory clearing pass is needed.
module pid_packet_rate_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pid[12:0], index[18:13], zero fill
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // entry_pid[12:0], entry_prev_count[28:13],
                                  // entry_count[44:29], entries_used[51:45], zero fill
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);
  localparam logic [UW-1:0] ONE_U   = UW'(1);

  pprt_pkg::state_t state_r, state_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] pos_r, pos_nxt;     // search position, or tick source
  logic [UW-1:0] k_r, k_nxt;         // shift index, or tick destination
  logic [pprt_pkg::PID_W-1:0] pid_r, pid_nxt;
  logic [pprt_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [pprt_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  pprt_pkg::entry_t res_ent_r, res_ent_nxt;
  logic en_r, en_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [pprt_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  pprt_pkg::entry_t out_ent_r, out_ent_nxt;
  logic [pprt_pkg::USED_W-1:0] out_used_r, out_used_nxt;

  pprt_pkg::entry_t mem [TABLE_DEPTH];
  pprt_pkg::entry_t rdata_r;
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  pprt_pkg::entry_t wr_data;

  logic [UW-1:0] km1;
  logic [31:0] used32;
  logic in_acc;

  assign km1       = k_r - ONE_U;
  assign used32    = 32'(used_nxt);
  assign in_tready = (state_r == pprt_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'd0, out_used_r, out_ent_r.count, out_ent_r.prev, out_ent_r.key};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    pid_nxt        = pid_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    en_nxt         = (cfg_valid && cfg_ready) ? cfg_data : en_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_used_nxt   = out_used_r;
    rd_en          = 1'b0;
    rd_addr        = pos_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = pos_r[AW-1:0];
    wr_data        = rdata_r;

    unique case (state_r)
      pprt_pkg::ST_IDLE: begin
        if (in_acc) begin
          pid_nxt        = in_tdata[pprt_pkg::PID_W-1:0];
          idx_nxt        = in_tdata[pprt_pkg::PID_W +: pprt_pkg::IDX_W];
          res_status_nxt = pprt_pkg::STAT_DONE;
          res_ent_nxt    = '0;
          pos_nxt        = '0;
          k_nxt          = '0;
          unique case (in_tuser)
            pprt_pkg::FN_PACKET: begin
              if (en_r) begin
                state_nxt = pprt_pkg::ST_P_RD;
              end else begin
                res_status_nxt = pprt_pkg::STAT_DISABLED;
                state_nxt      = pprt_pkg::ST_FIN;
              end
            end
            pprt_pkg::FN_TICK: begin
              if (en_r) begin
                state_nxt = pprt_pkg::ST_T_RD;
              end else begin
                res_status_nxt = pprt_pkg::STAT_DISABLED;
                state_nxt      = pprt_pkg::ST_FIN;
              end
            end
            pprt_pkg::FN_READ: begin
              state_nxt = pprt_pkg::ST_R_RD;
            end
            default: begin
              used_nxt  = '0;
              state_nxt = pprt_pkg::ST_FIN;
            end
          endcase
        end
      end

      pprt_pkg::ST_P_RD: begin
        if (pos_r < used_r) begin
          rd_en     = 1'b1;
          state_nxt = pprt_pkg::ST_P_CMP;
        end else if (used_r == DEPTH_U) begin
          res_status_nxt = pprt_pkg::STAT_FULL;
          state_nxt      = pprt_pkg::ST_FIN;
        end else begin
          k_nxt     = used_r;
          state_nxt = pprt_pkg::ST_M_RD;
        end
      end

      pprt_pkg::ST_P_CMP: begin
        if (rdata_r.key < pid_r) begin
          pos_nxt   = pos_r + ONE_U;
          state_nxt = pprt_pkg::ST_P_RD;
        end else if (rdata_r.key == pid_r) begin
          // Present already: bump the count, holding at the top value.
          wr_en         = 1'b1;
          wr_data.count = (rdata_r.count == pprt_pkg::CNT_MAX)
                          ? rdata_r.count
                          : rdata_r.count + pprt_pkg::CNT_W'(1);
          state_nxt     = pprt_pkg::ST_FIN;
        end else if (used_r == DEPTH_U) begin
          res_status_nxt = pprt_pkg::STAT_FULL;
          state_nxt      = pprt_pkg::ST_FIN;
        end else begin
          k_nxt     = used_r;
          state_nxt = pprt_pkg::ST_M_RD;
        end
      end

      pprt_pkg::ST_M_RD: begin
        if (k_r > pos_r) begin
          rd_en     = 1'b1;
          rd_addr   = km1[AW-1:0];
          state_nxt = pprt_pkg::ST_M_WR;
        end else begin
          wr_en         = 1'b1;
          wr_data.key   = pid_r;
          wr_data.prev  = '0;
          wr_data.count = pprt_pkg::CNT_W'(1);
          used_nxt      = used_r + ONE_U;
          state_nxt     = pprt_pkg::ST_FIN;
        end
      end

      pprt_pkg::ST_M_WR: begin
        wr_en     = 1'b1;
        wr_addr   = k_r[AW-1:0];
        k_nxt     = km1;
        state_nxt = pprt_pkg::ST_M_RD;
      end

      pprt_pkg::ST_T_RD: begin
        if (pos_r < used_r) begin
          rd_en     = 1'b1;
          state_nxt = pprt_pkg::ST_T_CMP;
        end else begin
          used_nxt  = k_r;
          state_nxt = pprt_pkg::ST_FIN;
        end
      end

      pprt_pkg::ST_T_CMP: begin
        // Compaction writes at or below the source, so unread entries stay intact.
        if ((rdata_r.count != '0) || (rdata_r.prev != '0)) begin
          wr_en         = 1'b1;
          wr_addr       = k_r[AW-1:0];
          wr_data.prev  = rdata_r.count;
          wr_data.count = '0;
          k_nxt         = k_r + ONE_U;
        end
        pos_nxt   = pos_r + ONE_U;
        state_nxt = pprt_pkg::ST_T_RD;
      end

      pprt_pkg::ST_R_RD: begin
        if (32'(idx_r) < 32'(used_r)) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(idx_r);
          state_nxt = pprt_pkg::ST_R_WAIT;
        end else begin
          res_status_nxt = pprt_pkg::STAT_RANGE;
          state_nxt      = pprt_pkg::ST_FIN;
        end
      end

      pprt_pkg::ST_R_WAIT: begin
        res_ent_nxt = rdata_r;
        state_nxt   = pprt_pkg::ST_FIN;
      end

      pprt_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ent_nxt    = res_ent_r;
          out_used_nxt   = used32[pprt_pkg::USED_W-1:0];
          state_nxt      = pprt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pprt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pprt_pkg::ST_IDLE;
      used_r      <= '0;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    k_r          <= k_nxt;
    pid_r        <= pid_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_used_r   <= out_used_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_U)
    else $error("entry count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new item taken while one is in work");

  a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_addr) < TABLE_DEPTH) && (32'(wr_addr) <= 32'(used_r)))
    else $error("memory write outside the used region");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != pprt_pkg::STAT_DONE) |-> (out_ent_r == '0))
    else $error("entry fields nonzero on a result without a read");

  a_tick_compacts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pprt_pkg::ST_T_RD) || (state_r == pprt_pkg::ST_T_CMP) |-> k_r <= pos_r)
    else $error("tick destination passed its source");

endmodule
